[hw/rtl/pwc_pkg.sv]
package pwc_pkg;

   localparam int unsigned TICK_W          = 24;
   localparam int unsigned MIN_PULSE_W     = 16;
   localparam int unsigned COUNT_W         = 10;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam int unsigned CSR_DATA_W      = 24;
   localparam int unsigned REQ_DATA_W      = 8;
   localparam int unsigned RSP_DATA_W      = 88;
   localparam int unsigned MAX_PULSES_DEFAULT = 512;
   localparam int unsigned MIN_VALID_PULSES   = 4;

   localparam logic [TICK_W-1:0]      TICK_MAX          = '1;
   localparam logic [MIN_PULSE_W-1:0] MIN_PULSE_RESET   = 16'd100;
   localparam logic [TICK_W-1:0]      GAP_TIMEOUT_RESET = 24'd10000;
   localparam logic [TICK_W-1:0]      WAIT_TIMEOUT_RESET = 24'd5000000;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TIMEOUT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      KIND_PULSE         = 2'd0,
      KIND_FRAME_VALID   = 2'd1,
      KIND_FRAME_INVALID = 2'd2,
      KIND_WAIT_TIMEOUT  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [MIN_PULSE_W-1:0] min_pulse_ticks;
      logic [TICK_W-1:0]      gap_timeout_ticks;
      logic [TICK_W-1:0]      wait_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic               pulse_level;
      logic [TICK_W-1:0]  duration;
      logic [COUNT_W-1:0] pulse_count;
      logic [TICK_W-1:0]  shortest;
      logic [TICK_W-1:0]  longest;
   } result_type;

endpackage

[hw/rtl/pwc_engine.sv]
module pwc_engine #(
   parameter int unsigned MAX_PULSES = pwc_pkg::MAX_PULSES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                arm,
   input  logic                level,
   input  pwc_pkg::cfg_type    cfg,
   output logic                res_valid,
   output pwc_pkg::result_type res
);

   localparam int unsigned KEPT_W = $clog2(MAX_PULSES + 1);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_WAIT    = 2'd1,
      PH_MEASURE = 2'd2
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic                            prev_level_ff, prev_level_in;
   logic [pwc_pkg::TICK_W-1:0]      tick_count_ff, tick_count_in;
   logic [KEPT_W-1:0]               kept_count_ff, kept_count_in;
   logic [pwc_pkg::TICK_W-1:0]      min_seen_ff, min_seen_in;
   logic [pwc_pkg::TICK_W-1:0]      max_seen_ff, max_seen_in;

   logic [pwc_pkg::TICK_W-1:0]      tick_inc;
   logic [KEPT_W+pwc_pkg::COUNT_W-1:0] kept_ext;
   logic                            frame_full;
   logic                            frame_good;

   assign tick_inc   = (tick_count_ff == pwc_pkg::TICK_MAX) ? tick_count_ff
                                                            : tick_count_ff + 1'b1;
   assign frame_full = (kept_count_ff >= KEPT_W'(MAX_PULSES));
   assign frame_good = (kept_count_ff >= KEPT_W'(pwc_pkg::MIN_VALID_PULSES));
   assign kept_ext   = {{pwc_pkg::COUNT_W{1'b0}}, kept_count_in};

   always_comb begin
      phase_in      = phase_ff;
      prev_level_in = prev_level_ff;
      tick_count_in = tick_count_ff;
      kept_count_in = kept_count_ff;
      min_seen_in   = min_seen_ff;
      max_seen_in   = max_seen_ff;
      res_valid     = 1'b0;
      res.kind        = pwc_pkg::KIND_PULSE;
      res.pulse_level = 1'b0;
      res.duration    = '0;

      if (arm) begin
         kept_count_in = '0;
         min_seen_in   = pwc_pkg::TICK_MAX;
         max_seen_in   = '0;
         tick_count_in = '0;
         if (level) begin
            phase_in      = PH_MEASURE;
            prev_level_in = 1'b1;
         end else begin
            phase_in = PH_WAIT;
         end
      end else begin
         case (phase_ff)
            PH_WAIT: begin
               tick_count_in = tick_inc;
               if (level) begin
                  phase_in      = PH_MEASURE;
                  prev_level_in = 1'b1;
                  tick_count_in = '0;
               end else if (tick_inc > cfg.wait_timeout_ticks) begin
                  res_valid = 1'b1;
                  res.kind  = pwc_pkg::KIND_WAIT_TIMEOUT;
                  phase_in  = PH_IDLE;
               end
            end
            PH_MEASURE: begin
               if (frame_full) begin
                  res_valid = 1'b1;
                  res.kind  = frame_good ? pwc_pkg::KIND_FRAME_VALID
                                         : pwc_pkg::KIND_FRAME_INVALID;
                  phase_in  = PH_IDLE;
               end else begin
                  tick_count_in = tick_inc;
                  if (level != prev_level_ff) begin
                     prev_level_in = level;
                     tick_count_in = '0;
                     if (tick_inc >= {8'd0, cfg.min_pulse_ticks}) begin
                        kept_count_in   = kept_count_ff + 1'b1;
                        min_seen_in     = (tick_inc < min_seen_ff) ? tick_inc : min_seen_ff;
                        max_seen_in     = (tick_inc > max_seen_ff) ? tick_inc : max_seen_ff;
                        res_valid       = 1'b1;
                        res.kind        = pwc_pkg::KIND_PULSE;
                        res.pulse_level = prev_level_ff;
                        res.duration    = tick_inc;
                     end
                  end else if ((tick_inc > cfg.gap_timeout_ticks) &&
                               (kept_count_ff != '0)) begin
                     res_valid = 1'b1;
                     res.kind  = frame_good ? pwc_pkg::KIND_FRAME_VALID
                                            : pwc_pkg::KIND_FRAME_INVALID;
                     phase_in  = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end

      res.pulse_count = kept_ext[pwc_pkg::COUNT_W-1:0];
      res.shortest    = min_seen_in;
      res.longest     = max_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         prev_level_ff <= 1'b1;
         tick_count_ff <= '0;
         kept_count_ff <= '0;
         min_seen_ff   <= pwc_pkg::TICK_MAX;
         max_seen_ff   <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         prev_level_ff <= prev_level_in;
         tick_count_ff <= tick_count_in;
         kept_count_ff <= kept_count_in;
         min_seen_ff   <= min_seen_in;
         max_seen_ff   <= max_seen_in;
      end
   end

endmodule

[hw/rtl/ook_pulse_width_capture_core.sv]
// rsp_tvalid rises once an accepted request that yields a result has passed through
// the input register and then the result register.
// Throughput: one request per cycle; the input register and the result register
// each advance whenever the stage after them is free or being drained.
// Reset (synchronous, active high): pipeline emptied, capture idle, statistics cleared,
// configuration registers back to their default values.
module ook_pulse_width_capture_core #(
   parameter int unsigned MAX_PULSES = pwc_pkg::MAX_PULSES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pwc_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] arm, [1] level
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // pulse_level, duration,
                                                          // pulse_count, shortest, longest
   output logic [1:0]                         rsp_tuser,  // kind
   input  logic                               csr_we,
   input  logic [pwc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pwc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pwc_pkg::cfg_type    cfg_ff;
   logic                s1_valid_ff;
   logic                arm_ff;
   logic                level_ff;
   logic                rsp_valid_ff;
   pwc_pkg::result_type rsp_ff;

   logic                advance;
   logic                res_valid;
   pwc_pkg::result_type res;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_ticks    <= pwc_pkg::MIN_PULSE_RESET;
         cfg_ff.gap_timeout_ticks  <= pwc_pkg::GAP_TIMEOUT_RESET;
         cfg_ff.wait_timeout_ticks <= pwc_pkg::WAIT_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pwc_pkg::CSR_MIN_PULSE:
               cfg_ff.min_pulse_ticks <= csr_wdata[pwc_pkg::MIN_PULSE_W-1:0];
            pwc_pkg::CSR_GAP_TIMEOUT:  cfg_ff.gap_timeout_ticks  <= csr_wdata;
            pwc_pkg::CSR_WAIT_TIMEOUT: cfg_ff.wait_timeout_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         arm_ff   <= req_tdata[0];
         level_ff <= req_tdata[1];
      end
   end

   pwc_engine #(
      .MAX_PULSES (MAX_PULSES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .arm       (arm_ff),
      .level     (level_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'd0, rsp_ff.longest, rsp_ff.shortest, rsp_ff.pulse_count,
                        rsp_ff.duration, rsp_ff.pulse_level};

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int unsigned MAX_KEPT = pwc_pkg::MAX_PULSES_DEFAULT;
   localparam logic [pwc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      CAP_IDLE,
      CAP_WAIT,
      CAP_MEASURE
   } cap_phase_type;

   typedef struct packed {
      logic level;
      logic arm;
   } tick_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic [pwc_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                            rsp_tready = 1'b0;
   logic                            csr_we     = 1'b0;
   logic [pwc_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [pwc_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                            req_tready;
   logic                            rsp_tvalid;
   logic [pwc_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]                      rsp_tuser;

   // predictor state and its copy of the registers
   cap_phase_type              cap_phase = CAP_IDLE;
   logic                       cap_prev  = 1'b1;
   logic [pwc_pkg::TICK_W-1:0] cap_ticks = '0;
   int unsigned                cap_kept  = 0;
   logic [pwc_pkg::TICK_W-1:0] cap_min   = pwc_pkg::TICK_MAX;
   logic [pwc_pkg::TICK_W-1:0] cap_max   = '0;
   logic [pwc_pkg::MIN_PULSE_W-1:0] cfg_min  = pwc_pkg::MIN_PULSE_RESET;
   logic [pwc_pkg::TICK_W-1:0]      cfg_gap  = pwc_pkg::GAP_TIMEOUT_RESET;
   logic [pwc_pkg::TICK_W-1:0]      cfg_wait = pwc_pkg::WAIT_TIMEOUT_RESET;

   tick_type             pending_ticks[$];
   pwc_pkg::result_type  expected_results[$];
   bit                   steady       = 1'b0;
   bit                   req_taken    = 1'b0;
   int unsigned          errors       = 0;
   int unsigned          ticks_sent   = 0;
   int unsigned          ticks_queued = 0;
   int unsigned          kind_seen[4];
   pwc_pkg::result_type  got;
   pwc_pkg::result_type  want;
   int unsigned          phase_start;

   always #5 clock = ~clock;

   ook_pulse_width_capture_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic [pwc_pkg::TICK_W-1:0] sat_inc(
      input logic [pwc_pkg::TICK_W-1:0] v);
      return (v == pwc_pkg::TICK_MAX) ? v : v + 1'b1;
   endfunction

   function automatic void note_result(input pwc_pkg::kind_type k, input logic lvl,
                                       input logic [pwc_pkg::TICK_W-1:0] dur);
      pwc_pkg::result_type r;
      r.kind        = k;
      r.pulse_level = lvl;
      r.duration    = dur;
      r.pulse_count = pwc_pkg::COUNT_W'(cap_kept);
      r.shortest    = cap_min;
      r.longest     = cap_max;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void close_frame();
      note_result((cap_kept >= pwc_pkg::MIN_VALID_PULSES) ? pwc_pkg::KIND_FRAME_VALID
                                                          : pwc_pkg::KIND_FRAME_INVALID,
                  1'b0, '0);
      cap_phase = CAP_IDLE;
   endfunction

   function automatic void capture_tick(input logic arm, input logic lvl);
      logic [pwc_pkg::TICK_W-1:0] dur;
      logic                       held;
      if (arm) begin
         cap_kept  = 0;
         cap_min   = pwc_pkg::TICK_MAX;
         cap_max   = '0;
         cap_ticks = '0;
         cap_phase = CAP_WAIT;
         if (lvl) begin
            cap_phase = CAP_MEASURE;
            cap_prev  = 1'b1;
         end else if (cap_ticks > cfg_wait) begin
            note_result(pwc_pkg::KIND_WAIT_TIMEOUT, 1'b0, '0);
            cap_phase = CAP_IDLE;
         end
      end else if (cap_phase == CAP_WAIT) begin
         cap_ticks = sat_inc(cap_ticks);
         if (lvl) begin
            cap_phase = CAP_MEASURE;
            cap_prev  = 1'b1;
            cap_ticks = '0;
         end else if (cap_ticks > cfg_wait) begin
            note_result(pwc_pkg::KIND_WAIT_TIMEOUT, 1'b0, '0);
            cap_phase = CAP_IDLE;
         end
      end else if (cap_phase == CAP_MEASURE) begin
         if (cap_kept >= MAX_KEPT) begin
            close_frame();
         end else begin
            cap_ticks = sat_inc(cap_ticks);
            if (lvl != cap_prev) begin
               dur       = cap_ticks;
               held      = cap_prev;
               cap_prev  = lvl;
               cap_ticks = '0;
               if (dur >= cfg_min) begin
                  cap_kept++;
                  if (dur < cap_min) cap_min = dur;
                  if (dur > cap_max) cap_max = dur;
                  note_result(pwc_pkg::KIND_PULSE, held, dur);
               end
            end else if (cap_ticks > cfg_gap && cap_kept > 0) begin
               close_frame();
            end
         end
      end
   endfunction

   function automatic string show(input pwc_pkg::result_type r);
      return $sformatf("kind=%0d level=%0d duration=%0d count=%0d shortest=%0d longest=%0d",
                       r.kind, r.pulse_level, r.duration, r.pulse_count, r.shortest,
                       r.longest);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         capture_tick(pending_ticks[0].arm, pending_ticks[0].level);
         void'(pending_ticks.pop_front());
         ticks_sent++;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         req_taken = 1'b0;
         if (pending_ticks.size() > 0 && (steady || $urandom_range(99) >= 12)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {{(pwc_pkg::REQ_DATA_W-2){1'b0}}, pending_ticks[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind        = pwc_pkg::kind_type'(rsp_tuser);
         got.pulse_level = rsp_tdata[0];
         got.duration    = rsp_tdata[24:1];
         got.pulse_count = rsp_tdata[34:25];
         got.shortest    = rsp_tdata[58:35];
         got.longest     = rsp_tdata[82:59];
         kind_seen[got.kind]++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transaction: expected none, actual %s",
                     $time, show(got));
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: result mismatch: expected %s, actual %s",
                        $time, show(want), show(got));
            end
         end
      end
   end

   task automatic add_tick(input logic arm, input logic lvl);
      tick_type t;
      t.arm   = arm;
      t.level = lvl;
      pending_ticks.insert(pending_ticks.size(), t);
      ticks_queued++;
   endtask

   task automatic add_run(input logic lvl, input int unsigned n);
      repeat (n) add_tick(1'b0, lvl);
   endtask

   task automatic add_frame();
      int unsigned lead;
      int unsigned pulses;
      logic        lvl;
      lead = $urandom_range(0, cfg_wait + 2);
      if (lead == 0) begin
         add_tick(1'b1, 1'b1);
      end else begin
         add_tick(1'b1, 1'b0);
         add_run(1'b0, lead - 1);
      end
      lvl    = 1'b1;
      pulses = $urandom_range(0, 9);
      repeat (pulses) begin
         add_run(lvl, $urandom_range(1, cfg_min * 2 + 3));
         lvl = ~lvl;
      end
      case ($urandom_range(0, 9))
         0, 1: ;
         2: begin
            add_run(1'($urandom_range(0, 1)), $urandom_range(1, 4));
         end
         default: begin
            add_run(~lvl, cfg_gap + $urandom_range(1, 3));
         end
      endcase
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 10))
            add_tick($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic write_reg(input logic [pwc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pwc_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         pwc_pkg::CSR_MIN_PULSE:    cfg_min  = val[pwc_pkg::MIN_PULSE_W-1:0];
         pwc_pkg::CSR_GAP_TIMEOUT:  cfg_gap  = val;
         pwc_pkg::CSR_WAIT_TIMEOUT: cfg_wait = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for every transaction and result, then let the pipeline empty
   task automatic settle();
      while (pending_ticks.size() != 0 || expected_results.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default registers: a frame abandoned by a new arm
      add_tick(1'b1, 1'b1);
      add_run(1'b1, 100);
      add_run(1'b0, 100);
      add_run(1'b1, 50);
      add_tick(1'b1, 1'b0);
      add_run(1'b0, 3);
      settle();

      // short directed checks; upper bits of the min width write are dropped
      write_reg(pwc_pkg::CSR_MIN_PULSE, 24'hFF0002);
      write_reg(pwc_pkg::CSR_GAP_TIMEOUT, 24'd6);
      write_reg(pwc_pkg::CSR_WAIT_TIMEOUT, 24'd3);
      write_reg(CSR_UNUSED, 24'hABCDEF);
      add_run(1'b0, 2);
      add_tick(1'b1, 1'b0);
      add_run(1'b0, 5);
      add_tick(1'b1, 1'b1);
      add_run(1'b1, 2);
      add_run(1'b0, 1);
      add_run(1'b1, 3);
      add_run(1'b0, 2);
      add_run(1'b1, 8);
      add_tick(1'b1, 1'b0);
      add_tick(1'b0, 1'b1);
      add_run(1'b0, 3);
      add_tick(1'b1, 1'b1);
      add_run(1'b1, 3);
      settle();

      // narrowest limits
      write_reg(pwc_pkg::CSR_MIN_PULSE, 24'd0);
      write_reg(pwc_pkg::CSR_GAP_TIMEOUT, 24'd1);
      write_reg(pwc_pkg::CSR_WAIT_TIMEOUT, 24'd1);
      add_tick(1'b1, 1'b0);
      add_run(1'b0, 3);
      add_tick(1'b1, 1'b1);
      for (int i = 0; i < 8; i++) add_tick(1'b0, i[0]);
      add_run(1'b0, 3);
      settle();

      // widest limits: nothing times out, every pulse dropped
      write_reg(pwc_pkg::CSR_MIN_PULSE, 24'hFFFFFF);
      write_reg(pwc_pkg::CSR_GAP_TIMEOUT, 24'hFFFFFF);
      write_reg(pwc_pkg::CSR_WAIT_TIMEOUT, 24'hFFFFFF);
      add_tick(1'b1, 1'b0);
      add_run(1'b0, 30);
      add_run(1'b1, 20);
      add_run(1'b0, 20);
      add_run(1'b1, 20);
      settle();

      // fill the pulse store, back to back
      write_reg(pwc_pkg::CSR_MIN_PULSE, 24'd0);
      steady = 1'b1;
      add_tick(1'b1, 1'b1);
      for (int i = 0; i < MAX_KEPT + 6; i++) add_tick(1'b0, i[0]);
      add_tick(1'b1, 1'b0);
      add_run(1'b0, 4);
      settle();
      steady = 1'b0;

      for (int p = 0; p < 5; p++) begin
         write_reg(pwc_pkg::CSR_MIN_PULSE, pwc_pkg::CSR_DATA_W'($urandom_range(0, 6)));
         write_reg(pwc_pkg::CSR_GAP_TIMEOUT, pwc_pkg::CSR_DATA_W'($urandom_range(1, 20)));
         write_reg(pwc_pkg::CSR_WAIT_TIMEOUT, pwc_pkg::CSR_DATA_W'($urandom_range(1, 15)));
         phase_start = ticks_queued;
         while (ticks_queued - phase_start < 130) add_frame();
         settle();
      end

      $display("Sent %0d ticks; got %0d pulses, %0d valid frames, %0d invalid frames,",
               ticks_sent, kind_seen[pwc_pkg::KIND_PULSE],
               kind_seen[pwc_pkg::KIND_FRAME_VALID], kind_seen[pwc_pkg::KIND_FRAME_INVALID]);
      $display("%0d wait timeouts, %0d mismatches", kind_seen[pwc_pkg::KIND_WAIT_TIMEOUT],
               errors);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d ticks pending, %0d results outstanding",
               $time, pending_ticks.size(), expected_results.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
hw/rtl/pwc_pkg.sv
hw/rtl/pwc_engine.sv
hw/rtl/ook_pulse_width_capture_core.sv
tb/sv/tb.sv
